### hdl/obis_pkg.sv
// ----------------------------------------------------------------------------
// obis_pkg
// Shared types and constants of the identification-code value extractor.
// ----------------------------------------------------------------------------
package obis_pkg;

    localparam int NUM_CODES  = 4;
    localparam int CODE_W     = 48;
    localparam int VALUE_W    = 32;
    localparam int GAP_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int DEF_CODE_BYTES  = 6;
    localparam int DEF_VALUE_BYTES = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_IMPORT_POWER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_EXPORT_POWER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_IMPORT_ENERGY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_EXPORT_ENERGY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BYTES          = 3'd4;

    localparam logic [CODE_W-1:0] RST_CODE_IMPORT_POWER  = 48'h0100_0107_00FF;
    localparam logic [CODE_W-1:0] RST_CODE_EXPORT_POWER  = 48'h0100_0207_00FF;
    localparam logic [CODE_W-1:0] RST_CODE_IMPORT_ENERGY = 48'h0100_0108_00FF;
    localparam logic [CODE_W-1:0] RST_CODE_EXPORT_ENERGY = 48'h0100_0208_00FF;
    localparam logic [GAP_W-1:0]  RST_GAP_BYTES          = 4'd1;

    // one byte stage of the sliding window
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } win_tap_t;

    // per-byte control shared by all cells and trackers
    typedef struct packed {
        logic step;
        logic last;
    } track_ctl_t;

    // frame result of one code tracker
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               found;
    } track_res_t;

endpackage

### hdl/obis_byte_if.sv
// ----------------------------------------------------------------------------
// obis_byte_if
// Input channel: one frame byte and its end-of-frame mark per transaction.
// ----------------------------------------------------------------------------
interface obis_byte_if;
    logic                      valid;
    logic                      ready;
    logic [obis_pkg::BYTE_W-1:0] data_byte;
    logic                      frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

### hdl/obis_result_if.sv
// ----------------------------------------------------------------------------
// obis_result_if
// Output channel: the four values and found flags of one frame.
// ----------------------------------------------------------------------------
interface obis_result_if;
    logic                         valid;
    logic                         ready;
    logic [obis_pkg::VALUE_W-1:0] import_power;
    logic                         import_power_found;
    logic [obis_pkg::VALUE_W-1:0] export_power;
    logic                         export_power_found;
    logic [obis_pkg::VALUE_W-1:0] import_energy;
    logic                         import_energy_found;
    logic [obis_pkg::VALUE_W-1:0] export_energy;
    logic                         export_energy_found;

    modport source (
        output valid,
        output import_power, output import_power_found,
        output export_power, output export_power_found,
        output import_energy, output import_energy_found,
        output export_energy, output export_energy_found,
        input  ready
    );
    modport sink (
        input  valid,
        input  import_power, input import_power_found,
        input  export_power, input export_power_found,
        input  import_energy, input import_energy_found,
        input  export_energy, input export_energy_found,
        output ready
    );
endinterface

### hdl/obis_win_cell.sv
// ----------------------------------------------------------------------------
// obis_win_cell
// One byte stage of the sliding window; passes its byte to the next stage.
// ----------------------------------------------------------------------------
module obis_win_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  obis_pkg::track_ctl_t ctl,
    input  obis_pkg::win_tap_t   tap_in,
    output obis_pkg::win_tap_t   tap_out
);
    import obis_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // valid marks a byte of the current frame; drop it at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            valid_reg <= ctl.last ? 1'b0 : tap_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            data_reg <= tap_in.data;
        end
    end

    assign tap_out.valid = valid_reg;
    assign tap_out.data  = data_reg;

endmodule

### hdl/obis_tracker.sv
// ----------------------------------------------------------------------------
// obis_tracker
// Follows one code through a frame: first match, gap skip, value gather.
// ----------------------------------------------------------------------------
module obis_tracker #(
    parameter int VALUE_BYTES = obis_pkg::DEF_VALUE_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  obis_pkg::track_ctl_t          ctl,
    input  logic [obis_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          hit,
    input  logic [obis_pkg::GAP_W-1:0]    gap,
    output obis_pkg::track_res_t          res
);
    import obis_pkg::*;

    localparam int CNT_W = $clog2((2 ** GAP_W) + VALUE_BYTES);

    logic               matched_reg, matched_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] val_reg, val_next;

    always_comb
    begin
        matched_next = matched_reg;
        done_next    = done_reg;
        cnt_next     = cnt_reg;
        val_next     = val_reg;
        // advance skip/gather for a match taken on an earlier byte
        if (matched_reg && !done_reg && (cnt_reg != '0))
        begin
            if (cnt_reg <= CNT_W'(VALUE_BYTES))
            begin
                val_next = {val_reg[VALUE_W-BYTE_W-1:0], data_byte};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_next == '0)
            begin
                done_next = 1'b1;
            end
        end
        // first match in the frame only
        if (!matched_reg && hit)
        begin
            matched_next = 1'b1;
            cnt_next     = CNT_W'(gap) + CNT_W'(VALUE_BYTES);
            val_next     = '0;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            val_reg     <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.last)
            begin
                matched_reg <= 1'b0;
                done_reg    <= 1'b0;
                cnt_reg     <= '0;
                val_reg     <= '0;
            end
            else
            begin
                matched_reg <= matched_next;
                done_reg    <= done_next;
                cnt_reg     <= cnt_next;
                val_reg     <= val_next;
            end
        end
    end

    assign res.found = matched_next && done_next;
    assign res.value = res.found ? val_next : '0;

endmodule

### hdl/obis_value_extractor.sv
// ----------------------------------------------------------------------------
// obis_value_extractor
// Picks four big-endian values out of a meter frame by identification code.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one frame byte per transaction, frame_end set on the
//   last byte. result_out carries one transaction per frame with the four
//   values and found flags; a value reads zero when its flag is clear.
//   The user must write codes and the gap length (cfg_we/cfg_index/cfg_data)
//   only while the block is idle (unenforced); both survive frame boundaries.
// Timing:
//   One byte per cycle unless a result waits unread: a row of byte cells
//   shifts the window in a single step and each code tracker updates in
//   the same cycle. The result appears in the cycle after the frame's last
//   byte is accepted, from an output register.
// Reset and stall:
//   Reset loads the default codes and a gap of one byte and empties the
//   window and the trackers. While a result waits unread, byte_in.ready
//   stays low; it rises again in the cycle the result is taken, so the
//   next frame can continue with no bubble.
// ----------------------------------------------------------------------------
module obis_value_extractor #(
    parameter int CODE_BYTES  = obis_pkg::DEF_CODE_BYTES,
    parameter int VALUE_BYTES = obis_pkg::DEF_VALUE_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [obis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obis_pkg::CFG_DATA_W-1:0] cfg_data,
    obis_byte_if.sink                       byte_in,
    obis_result_if.source                   result_out
);
    import obis_pkg::*;

    localparam int WIN_W = CODE_BYTES * BYTE_W;

    // configuration registers
    logic [CODE_W-1:0] code_reg [NUM_CODES];
    logic [GAP_W-1:0]  gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg[0] <= RST_CODE_IMPORT_POWER;
            code_reg[1] <= RST_CODE_EXPORT_POWER;
            code_reg[2] <= RST_CODE_IMPORT_ENERGY;
            code_reg[3] <= RST_CODE_EXPORT_ENERGY;
            gap_reg     <= RST_GAP_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CODE_IMPORT_POWER:  code_reg[0] <= cfg_data[CODE_W-1:0];
                CFG_CODE_EXPORT_POWER:  code_reg[1] <= cfg_data[CODE_W-1:0];
                CFG_CODE_IMPORT_ENERGY: code_reg[2] <= cfg_data[CODE_W-1:0];
                CFG_CODE_EXPORT_ENERGY: code_reg[3] <= cfg_data[CODE_W-1:0];
                CFG_GAP_BYTES:          gap_reg     <= cfg_data[GAP_W-1:0];
                default: ; // ignore writes beyond the register list
            endcase
        end
    end

    // handshake: hold input while a finished result waits
    logic       out_valid_reg;
    track_ctl_t ctl;

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign ctl.step      = byte_in.valid && byte_in.ready;
    assign ctl.last      = byte_in.frame_end;

    // window: incoming byte plus a chain of CODE_BYTES-1 byte cells
    win_tap_t          taps [CODE_BYTES];
    logic [WIN_W-1:0]  window;
    logic              window_full;

    assign taps[0].valid = 1'b1;
    assign taps[0].data  = byte_in.data_byte;

    genvar k;
    generate
        for (k = 1; k < CODE_BYTES; k++)
        begin : g_cell
            obis_win_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .tap_in  (taps[k-1]),
                .tap_out (taps[k])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < CODE_BYTES; i++)
        begin
            window[i*BYTE_W +: BYTE_W] = taps[i].data;
        end
    end

    // full once the oldest stage holds a byte of this frame
    assign window_full = taps[CODE_BYTES-1].valid;

    // compare against each code; code bits above its width read as zero
    logic [NUM_CODES-1:0] hit;
    track_res_t           res [NUM_CODES];

    always_comb
    begin
        for (int c = 0; c < NUM_CODES; c++)
        begin
            logic [WIN_W-1:0] code_ext;
            for (int j = 0; j < WIN_W; j++)
            begin
                code_ext[j] = (j < CODE_W) ? code_reg[c][j] : 1'b0;
            end
            hit[c] = window_full && (window == code_ext);
        end
    end

    genvar t;
    generate
        for (t = 0; t < NUM_CODES; t++)
        begin : g_track
            obis_tracker #(
                .VALUE_BYTES (VALUE_BYTES)
            ) u_track (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .data_byte (byte_in.data_byte),
                .hit       (hit[t]),
                .gap       (gap_reg),
                .res       (res[t])
            );
        end
    endgenerate

    // output register: load on the frame's last byte, drop when taken
    track_res_t out_reg [NUM_CODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.step && ctl.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.last)
        begin
            for (int c = 0; c < NUM_CODES; c++)
            begin
                out_reg[c] <= res[c];
            end
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.import_power        = out_reg[0].value;
    assign result_out.import_power_found  = out_reg[0].found;
    assign result_out.export_power        = out_reg[1].value;
    assign result_out.export_power_found  = out_reg[1].found;
    assign result_out.import_energy       = out_reg[2].value;
    assign result_out.import_energy_found = out_reg[2].found;
    assign result_out.export_energy       = out_reg[3].value;
    assign result_out.export_energy_found = out_reg[3].found;

endmodule

### bench/obis_value_extractor_tb.sv
// ----------------------------------------------------------------------------
// obis_value_extractor_tb
// Streams meter frames byte by byte into the extractor and compares every
// frame report with a cycle-free model of the code matching, gap skipping
// and big-endian gathering. Directed frames cover the reset codes, short
// frames, overlapping codes, values cut off by the frame end and repeated
// codes; random frames under several register settings cover the rest,
// with random stalls on both channels and one long hold on the output.
// ----------------------------------------------------------------------------
module obis_value_extractor_tb;

    import obis_pkg::*;

    localparam int LONG_HOLD     = 80;   // output hold-off, in cycles
    localparam int SETTLE_CYCLES = 4;    // quiet cycles before a register write
    localparam int PHASE_BYTES   = 90;   // random bytes per register setting
    localparam int N_PHASES      = 6;

    typedef logic [BYTE_W-1:0] byte_t;

    // one frame report: the four values and their found flags
    typedef struct packed {
        logic [NUM_CODES-1:0][VALUE_W-1:0] value;
        logic [NUM_CODES-1:0]              found;
    } frame_rpt_t;

    localparam logic [CFG_IDX_W-1:0] CODE_REG_IDX [NUM_CODES] = '{
        CFG_CODE_IMPORT_POWER, CFG_CODE_EXPORT_POWER,
        CFG_CODE_IMPORT_ENERGY, CFG_CODE_EXPORT_ENERGY
    };
    localparam logic [CODE_W-1:0] RST_CODES [NUM_CODES] = '{
        RST_CODE_IMPORT_POWER, RST_CODE_EXPORT_POWER,
        RST_CODE_IMPORT_ENERGY, RST_CODE_EXPORT_ENERGY
    };

    string code_name [NUM_CODES] = '{
        "import_power", "export_power", "import_energy", "export_energy"
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    obis_byte_if   byte_ch ();
    obis_result_if res_ch ();

    obis_value_extractor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_ch),
        .result_out (res_ch)
    );

    // ------------------------------------------------------------------
    // Model of the extractor: register copies and per-frame tracking
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]  code_tbl [NUM_CODES];
    logic [GAP_W-1:0]   gap_len;
    logic [CODE_W-1:0]  win_bytes;
    int                 win_count;
    bit                 seen_code [NUM_CODES];
    int                 countdown [NUM_CODES];   // gap plus value bytes still due
    logic [VALUE_W-1:0] acc_value [NUM_CODES];
    bit                 value_done [NUM_CODES];

    frame_rpt_t frame_rpt_q [$];   // reports still owed by the block
    byte_t      frame_buf [$];     // frame being composed for sending

    int n_err;
    int n_sent;
    bit idle_on;        // allow random gaps and stalls
    bit hold_request;   // ask the receiver for one long hold-off

    function automatic void clear_frame_state();
        win_bytes = '0;
        win_count = 0;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            seen_code[i]  = 1'b0;
            countdown[i]  = 0;
            acc_value[i]  = '0;
            value_done[i] = 1'b0;
        end
    endfunction

    // Advance the model by one accepted byte; queue a report on frame end.
    function automatic void track_byte(input byte_t b, input logic last);
        frame_rpt_t rpt;
        // gather for codes matched on earlier bytes
        for (int i = 0; i < NUM_CODES; i++)
        begin
            if (seen_code[i] && !value_done[i] && countdown[i] > 0)
            begin
                if (countdown[i] <= DEF_VALUE_BYTES)
                    acc_value[i] = {acc_value[i][VALUE_W-BYTE_W-1:0], b};
                countdown[i]--;
                if (countdown[i] == 0)
                    value_done[i] = 1'b1;
            end
        end
        // shift the byte in, then look for first matches
        win_bytes = {win_bytes[CODE_W-BYTE_W-1:0], b};
        if (win_count < DEF_CODE_BYTES)
            win_count++;
        if (win_count >= DEF_CODE_BYTES)
        begin
            for (int i = 0; i < NUM_CODES; i++)
            begin
                if (!seen_code[i] && win_bytes == code_tbl[i])
                begin
                    seen_code[i]  = 1'b1;
                    countdown[i]  = int'(gap_len) + DEF_VALUE_BYTES;
                    acc_value[i]  = '0;
                    value_done[i] = 1'b0;
                end
            end
        end
        if (last)
        begin
            for (int i = 0; i < NUM_CODES; i++)
            begin
                rpt.found[i] = seen_code[i] && value_done[i];
                rpt.value[i] = rpt.found[i] ? acc_value[i] : '0;
            end
            frame_rpt_q.push_back(rpt);
            clear_frame_state();
        end
    endfunction

    function automatic byte_t code_byte(input int k, input int n);
        return code_tbl[k][BYTE_W*(DEF_CODE_BYTES-1-n) +: BYTE_W];
    endfunction

    // Filler leaning toward the byte values that make up real codes.
    function automatic byte_t noise_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] pick_code(input int i);
        logic [63:0]       wide;
        logic [CODE_W-1:0] c;
        wide = {$urandom(), $urandom()};
        c    = RST_CODES[i];
        case ($urandom_range(0, 4))
            0: ;
            1: c = wide[CODE_W-1:0];
            2: c[BYTE_W*$urandom_range(0, DEF_CODE_BYTES-1) +: BYTE_W] = wide[BYTE_W-1:0];
            3: c = '0;
            default: c = '1;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                // hold the output long enough for the block to fill and stall
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each result transaction with the oldest report
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_rpt_t want;
        frame_rpt_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.value[0] = res_ch.import_power;
            got.found[0] = res_ch.import_power_found;
            got.value[1] = res_ch.export_power;
            got.found[1] = res_ch.export_power_found;
            got.value[2] = res_ch.import_energy;
            got.found[2] = res_ch.import_energy_found;
            got.value[3] = res_ch.export_energy;
            got.found[3] = res_ch.export_energy_found;
            if (frame_rpt_q.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
            end
            else
            begin
                want = frame_rpt_q.pop_front();
                for (int i = 0; i < NUM_CODES; i++)
                begin
                    if (got.value[i] !== want.value[i])
                    begin
                        n_err++;
                        $display("%0t: %s mismatch: expected %h, actual %h",
                                 $time, code_name[i], want.value[i], got.value[i]);
                    end
                    if (got.found[i] !== want.found[i])
                    begin
                        n_err++;
                        $display("%0t: %s_found mismatch: expected %b, actual %b",
                                 $time, code_name[i], want.found[i], got.found[i]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks; all are entered and left at a rising edge
    // ------------------------------------------------------------------

    // Offer one byte, with an optional gap first, and wait for the transaction.
    task automatic send_byte(input byte_t b, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.frame_end <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        track_byte(b, last);
        n_sent++;
    endtask

    // Send the composed frame; mark its last byte as the frame end.
    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Drop valid, drain all reports, then let the pipeline go quiet.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (frame_rpt_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Raise a write and wait for the edge that takes it; the caller drops the enable after a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < NUM_CODES)
            code_tbl[idx] = data[CODE_W-1:0];
        else if (idx == CFG_GAP_BYTES)
            gap_len = data[GAP_W-1:0];
    endtask

    // Write every code, the gap word, and junk to the unused indexes.
    task automatic load_config(input logic [NUM_CODES-1:0][CODE_W-1:0] codes,
                               input logic [CFG_DATA_W-1:0] gap_word);
        for (int i = 0; i < NUM_CODES; i++)
            write_reg(CODE_REG_IDX[i], codes[i]);
        write_reg(CFG_GAP_BYTES, gap_word);
        for (int k = int'(CFG_GAP_BYTES) + 1; k < 2**CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'({$urandom(), $urandom()}));
        cfg_we <= 1'b0;
    endtask

    // Random frame: mostly filler, codes (some back to back, so they
    // overlap), gap and value bytes; sometimes cut short or pure noise.
    task automatic compose_frame();
        int n_rec;
        int k;
        int r;
        int cut;
        frame_buf.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 20)) frame_buf.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 4)) frame_buf.push_back(noise_byte());
            n_rec = $urandom_range(1, 4);
            for (r = 0; r < n_rec; r++)
            begin
                k = $urandom_range(0, NUM_CODES - 1);
                for (int n = 0; n < DEF_CODE_BYTES; n++)
                    frame_buf.push_back(code_byte(k, n));
                // let the next code stand in for this one's gap and value
                if (r < n_rec - 1 && $urandom_range(0, 3) == 0)
                    continue;
                repeat (int'(gap_len) + DEF_VALUE_BYTES) frame_buf.push_back(noise_byte());
                repeat ($urandom_range(0, 3)) frame_buf.push_back(noise_byte());
            end
            // cut the tail off so a value or a code runs into the frame end
            if ($urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, 8);
                while (cut > 0 && frame_buf.size() > 1)
                begin
                    void'(frame_buf.pop_back());
                    cut--;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset codes and gap: import-power code, one gap byte, all-ones value
    // ending exactly on the frame end.
    task automatic test_default_codes();
        frame_buf.delete();
        for (int n = 0; n < DEF_CODE_BYTES; n++)
            frame_buf.push_back(code_byte(0, n));
        frame_buf.push_back(8'h5A);
        repeat (DEF_VALUE_BYTES) frame_buf.push_back(8'hFF);
        send_frame();
    endtask

    // Frame shorter than a code: nothing may match before the window fills.
    task automatic test_short_frame();
        frame_buf.delete();
        for (int n = 0; n < DEF_CODE_BYTES - 1; n++)
            frame_buf.push_back(code_byte(2, n));
        send_frame();
    endtask

    // Extreme codes, zero gap with junk in the upper data bits. An all-ones
    // code is followed at once by the fourth code: the second code's bytes
    // form the first one's value, and the second match lands on the last
    // byte, so it must come back not found.
    task automatic test_overlap_and_cutoff();
        logic [NUM_CODES-1:0][CODE_W-1:0] codes;
        codes[0] = 48'hAAAA_AAAA_AAAA;
        codes[1] = '0;
        codes[2] = '1;
        codes[3] = RST_CODE_EXPORT_ENERGY;
        settle();
        load_config(codes, 48'hFFFF_FFFF_FFF0);
        frame_buf.delete();
        repeat (DEF_CODE_BYTES) frame_buf.push_back(8'hFF);
        for (int n = 0; n < DEF_CODE_BYTES; n++)
            frame_buf.push_back(code_byte(3, n));
        send_frame();
    endtask

    // Periodic code seen twice in a row: only the first match may count,
    // so the value starts with the repeated byte.
    task automatic test_repeated_code();
        frame_buf.delete();
        repeat (DEF_CODE_BYTES + 1) frame_buf.push_back(8'hAA);
        repeat (DEF_VALUE_BYTES - 1) frame_buf.push_back(8'h00);
        send_frame();
    endtask

    // Hold the output while frames keep coming so the input backs up.
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (5)
        begin
            compose_frame();
            send_frame();
        end
    endtask

    // Random frames under several settings; the last one runs flat out.
    task automatic test_random_frames();
        logic [NUM_CODES-1:0][CODE_W-1:0] codes;
        logic [63:0]                      wide;
        logic [GAP_W-1:0]                 g;
        int                               start;
        for (int p = 0; p < N_PHASES; p++)
        begin
            wide = {$urandom(), $urandom()};
            for (int i = 0; i < NUM_CODES; i++)
                codes[i] = (p == N_PHASES - 1) ? RST_CODES[i] : pick_code(i);
            if (p == 3)
                codes[1] = codes[0];   // duplicate codes match together
            if (p == 0)
                g = '0;
            else if (p == 1)
                g = '1;
            else if (p == N_PHASES - 1)
                g = RST_GAP_BYTES;
            else
                g = GAP_W'($urandom_range(0, 15));
            settle();
            load_config(codes, {wide[CFG_DATA_W-1:GAP_W], g});
            if (p == N_PHASES - 1)
                idle_on = 1'b0;
            start = n_sent;
            while (n_sent - start < PHASE_BYTES)
            begin
                compose_frame();
                send_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.frame_end = 1'b0;
        idle_on           = 1'b1;
        hold_request      = 1'b0;
        n_err             = 0;
        n_sent            = 0;
        for (int i = 0; i < NUM_CODES; i++)
            code_tbl[i] = RST_CODES[i];
        gap_len = RST_GAP_BYTES;
        clear_frame_state();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_codes();
        test_short_frame();
        test_overlap_and_cutoff();
        test_repeated_code();
        test_backpressure();
        test_random_frames();
        settle();

        if (n_err == 0)
            $display("obis_value_extractor_tb: done, clean");
        else
            $display("obis_value_extractor_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("obis_value_extractor_tb: done, errors");
        $finish;
    end

endmodule
